FILE: rtl/core/desrf_pkg.sv
// Shared constants, permutation tables and helper functions of the DES round unit.
`default_nettype none

package desrf_pkg;

  // Field and word widths
  localparam int ROUND_W  = 4;
  localparam int HALF_W   = 32;
  localparam int KEY_W    = 64;
  localparam int CD_W     = 56;
  localparam int HALF_CD_W = 28;
  localparam int SUBKEY_W = 48;
  localparam int NUM_SBOX = 8;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_KEY_ORDER = 1'd1;

  // Tables use DES numbering: entry value 1 names the most significant bit
  localparam int E_TAB [SUBKEY_W] = '{
    32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11, 12, 13,
    12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
    24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1};

  localparam int P_TAB [HALF_W] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25};

  localparam int PC1_TAB [CD_W] = '{
    57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
    10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
    14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};

  localparam int PC2_TAB [SUBKEY_W] = '{
    14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
    23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};

  // Total left rotation of C and D after each round (running sum of the shifts)
  localparam logic [4:0] ROT_CUM [16] = '{
    5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

  localparam logic [3:0] SBOX [NUM_SBOX][64] = '{
    '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
      4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
      4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
      4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
      4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
      4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
      4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
    '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
      4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
      4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
      4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
      4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
      4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
      4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
      4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
    '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
      4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
      4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
      4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
      4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
      4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
      4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
    '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
      4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
      4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
      4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
      4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
      4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
      4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
      4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
    '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
      4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
      4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
      4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
      4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
      4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
      4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
      4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
    '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
      4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
      4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
      4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
      4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
      4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
      4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
      4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
    '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
      4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
      4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
      4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
      4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
      4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
      4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
      4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
    '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
      4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
      4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
      4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
      4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
      4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
      4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
      4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}};

  // Expand a right half to 48 bits
  function automatic logic [SUBKEY_W-1:0] e_expand(input logic [HALF_W-1:0] r);
    logic [SUBKEY_W-1:0] res;
    for (int i = 0; i < SUBKEY_W; i++) begin
      res[SUBKEY_W-1-i] = r[HALF_W-E_TAB[i]];
    end
    return res;
  endfunction

  // Apply the P permutation to the S-box outputs
  function automatic logic [HALF_W-1:0] p_permute(input logic [HALF_W-1:0] s);
    logic [HALF_W-1:0] res;
    for (int i = 0; i < HALF_W; i++) begin
      res[HALF_W-1-i] = s[HALF_W-P_TAB[i]];
    end
    return res;
  endfunction

  // Select the 56 key bits into C and D; parity bits drop out
  function automatic logic [CD_W-1:0] pc1_select(input logic [KEY_W-1:0] k);
    logic [CD_W-1:0] res;
    for (int i = 0; i < CD_W; i++) begin
      res[CD_W-1-i] = k[KEY_W-PC1_TAB[i]];
    end
    return res;
  endfunction

  // Compress rotated C and D to the 48-bit subkey
  function automatic logic [SUBKEY_W-1:0] pc2_select(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] res;
    for (int i = 0; i < SUBKEY_W; i++) begin
      res[SUBKEY_W-1-i] = cd[CD_W-PC2_TAB[i]];
    end
    return res;
  endfunction

  // Rotate a 28-bit half left by 1..28 places
  function automatic logic [HALF_CD_W-1:0] rotl28(input logic [HALF_CD_W-1:0] v,
                                                  input logic [4:0] amt);
    logic [CD_W-1:0] dbl;
    dbl = {v, v} << amt;
    return dbl[CD_W-1:HALF_CD_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/desrf_if.sv
// Valid/ready channel interfaces for the DES round unit input and result streams.
`default_nettype none

interface desrf_in_if;
  import desrf_pkg::*;

  logic               valid;
  logic               ready;
  logic [ROUND_W-1:0] round_index;
  logic [HALF_W-1:0]  right_half;

  modport source (output valid, round_index, right_half, input ready);
  modport sink   (input valid, round_index, right_half, output ready);
endinterface

interface desrf_out_if;
  import desrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] round_output;

  modport source (output valid, round_output, input ready);
  modport sink   (input valid, round_output, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/desrf_sbox_perm.sv
// S-box substitution layer and P permutation of the DES f function.
`default_nettype none

module desrf_sbox_perm (
  input  logic [desrf_pkg::SUBKEY_W-1:0] mix_i,
  output logic [desrf_pkg::HALF_W-1:0]   f_o
);
  import desrf_pkg::*;

  logic [HALF_W-1:0] sub_out;

  // Look up each 6-bit group: row from the outer bits, column from the inner four
  always_comb begin
    logic [5:0] six;
    sub_out = '0;
    for (int g = 0; g < NUM_SBOX; g++) begin
      six = mix_i[SUBKEY_W-1-6*g -: 6];
      sub_out[HALF_W-1-4*g -: 4] = SBOX[g][{six[5], six[0], six[4:1]}];
    end
  end

  assign f_o = p_permute(sub_out);

endmodule

`default_nettype wire

FILE: rtl/core/des_round_function_keyed_unit.sv
// Top level of the DES round function unit with on-the-fly key schedule.
// Throughput: one transaction per cycle while out_if is ready, through three
// register stages (key rotation and expansion, subkey mix, S-box and P into the
// output register).
// Reset clears the stage valid bits, the key (all zero) and reverse_key_order.
`default_nettype none

module des_round_function_keyed_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  desrf_in_if.sink                        in_if,
  desrf_out_if.source                     out_if,
  input  logic                            cfg_we,
  input  logic [desrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [desrf_pkg::KEY_W-1:0]     cfg_wdata
);
  import desrf_pkg::*;

  // Configuration: key kept in its PC-1 selected form
  logic [CD_W-1:0] key_cd_r;
  logic            rev_order_r;

  // Stage 1: rotated C/D and expanded right half
  logic                v1_r;
  logic [CD_W-1:0]     cd_rot_r;
  logic [SUBKEY_W-1:0] e_r;
  // Stage 2: expanded half mixed with the subkey
  logic                v2_r;
  logic [SUBKEY_W-1:0] mix_r;
  // Stage 3: result register
  logic                v3_r;
  logic [HALF_W-1:0]   f_r;

  logic                rdy1, rdy2, rdy3;
  logic [ROUND_W-1:0]  key_round;
  logic [CD_W-1:0]     cd_rot_nxt;
  logic [SUBKEY_W-1:0] mix_nxt;
  logic [HALF_W-1:0]   f_nxt;

  // A stage takes new data when empty or when its content moves on
  assign rdy3 = !v3_r || out_if.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cd_r    <= '0;
      rev_order_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CIPHER_KEY:        key_cd_r    <= pc1_select(cfg_wdata);
        CFG_REVERSE_KEY_ORDER: rev_order_r <= cfg_wdata[0];
        default:               ;
      endcase
    end
  end

  // Mirror the round for reverse order and rotate C and D to that round
  always_comb begin
    key_round  = rev_order_r ? ~in_if.round_index : in_if.round_index;
    cd_rot_nxt = {rotl28(key_cd_r[CD_W-1:HALF_CD_W], ROT_CUM[key_round]),
                  rotl28(key_cd_r[HALF_CD_W-1:0], ROT_CUM[key_round])};
  end

  assign mix_nxt = e_r ^ pc2_select(cd_rot_r);

  desrf_sbox_perm u_sbox_perm (
    .mix_i (mix_r),
    .f_o   (f_nxt)
  );

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_if.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Advance the payload; hold it while the next stage is stalled
  always_ff @(posedge clk) begin
    if (rdy1 && in_if.valid) begin
      cd_rot_r <= cd_rot_nxt;
      e_r      <= e_expand(in_if.right_half);
    end
    if (rdy2 && v1_r) begin
      mix_r <= mix_nxt;
    end
    if (rdy3 && v2_r) begin
      f_r <= f_nxt;
    end
  end

  assign out_if.valid        = v3_r;
  assign out_if.round_output = f_r;

endmodule

`default_nettype wire
